[rtl/core/aesg_pkg.sv]
// Shared types and constants for the eased animation step generator.
// No dependencies; imported by aesg_div, aesg_seq and the top level.
package aesg_pkg;

	localparam int STEP_W    = 8;
	localparam int TRAVEL_W  = 16;
	localparam int MOTION_W  = 17;
	localparam int SQSUM_W   = 23;
	localparam int PROD_W    = 32;
	localparam int MUL_A_W   = 24;

	localparam int STEP_COUNT_RST = 16;
	// 1^2 + ... + n^2 for the reset step count
	localparam logic [SQSUM_W-1:0] SQSUM_RST =
		SQSUM_W'(STEP_COUNT_RST * (STEP_COUNT_RST + 1) * (2 * STEP_COUNT_RST + 1) / 6);
	localparam logic [PROD_W-1:0] FIXED_STEP = PROD_W'(4);

	typedef enum logic [1:0] {
		PATH_LINEAR,
		PATH_SQ_INC,
		PATH_SQ_DEC,
		PATH_FIXED
	} path_mode_t;

	typedef enum logic [1:0] {
		REG_PATH_MODE,
		REG_STEP_COUNT,
		REG_TRAVEL_TOTAL,
		REG_BOUNCE
	} cfg_reg_t;

	typedef struct packed {
		path_mode_t            path_mode;
		logic [STEP_W-1:0]     step_count;
		logic [TRAVEL_W-1:0]   travel_total;
		logic                  bounce_enable;
	} cfg_t;

	typedef struct packed {
		logic [TRAVEL_W-1:0]   step_pixels;
		logic [MOTION_W-1:0]   motion_so_far;
		logic [STEP_W-1:0]     step_index;
		logic                  return_phase;
		logic                  active;
	} result_t;

	typedef struct packed {
		logic                  start;
		logic [PROD_W-1:0]     dividend;
		logic [SQSUM_W-1:0]    divisor;
	} div_req_t;

endpackage

[rtl/core/aesg_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on aesg_pkg; used by aesg_seq. Divisor must be nonzero.
module aesg_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  aesg_pkg::div_req_t       req,
	output logic                     done,
	output logic [aesg_pkg::PROD_W-1:0] quotient
);
	import aesg_pkg::*;

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [SQSUM_W-1:0] rem_q;
	logic [SQSUM_W-1:0] div_q;
	logic [PROD_W-1:0]  quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [SQSUM_W:0]   rem_sh;
	logic [SQSUM_W:0]   diff;
	logic               fits;

	// dividend bits shift out of the top of quo_q as quotient bits shift in
	assign rem_sh = {rem_q, quo_q[PROD_W-1]};
	assign diff   = rem_sh - {1'b0, div_q};
	assign fits   = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[SQSUM_W-1:0] : rem_sh[SQSUM_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/core/aesg_seq.sv]
// Step sequencer: state registers, shared 24x8 multiplier and control of the
// divider. Depends on aesg_pkg and aesg_div; used by the top level.
module aesg_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  aesg_pkg::cfg_t    cfg,
	input  logic              start,
	input  logic              restart,
	output logic              ready,
	output logic              res_valid,
	input  logic              res_take,
	output aesg_pkg::result_t res
);
	import aesg_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQ_MUL,
		S_SQ_ADD,
		S_SIZE,
		S_MUL1,
		S_MUL2,
		S_DIV_GO,
		S_DIV_WAIT,
		S_GOT,
		S_FINISH,
		S_RESULT
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic                ret_q;
	logic [MOTION_W-1:0] motion_q;
	logic [SQSUM_W-1:0]  sqsum_q;
	logic [STEP_W-1:0]   k_q;
	logic [STEP_W-1:0]   idx_q;
	logic                loop_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SQSUM_W-1:0]  acc_q;
	logic [PROD_W-1:0]   sum_q;
	logic [PROD_W-1:0]   first_q;
	logic [PROD_W-1:0]   size_q;
	result_t             res_q;

	logic [STEP_W-1:0]   n;
	logic [TRAVEL_W-1:0] t;
	logic [STEP_W-1:0]   m;
	logic [MUL_A_W-1:0]  mul_a;
	logic [STEP_W-1:0]   mul_b;
	logic [PROD_W-1:0]   mul_p;
	logic [SQSUM_W-1:0]  acc_new;
	div_req_t            div_req;
	logic                div_done;
	logic [PROD_W-1:0]   div_quo;
	logic [PROD_W-1:0]   cnt_full;
	logic [TRAVEL_W-1:0] cnt;
	logic [STEP_W-1:0]   step_next;
	logic                turn;
	logic [MOTION_W-1:0] motion_new;
	logic                is_sq;

	assign n     = cfg.step_count;
	assign t     = cfg.travel_total;
	assign is_sq = (cfg.path_mode == PATH_SQ_INC) || (cfg.path_mode == PATH_SQ_DEC);

	always_comb begin
		m = (cfg.path_mode == PATH_SQ_DEC) ? (n - k_q) : (k_q + STEP_W'(1));
		unique case (state_q)
			S_SQ_MUL: begin
				mul_a = MUL_A_W'(k_q);
				mul_b = k_q;
			end
			S_MUL1: begin
				mul_a = MUL_A_W'(t);
				mul_b = m;
			end
			default: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = m;
			end
		endcase
		mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
		acc_new = acc_q + prod_q[SQSUM_W-1:0];
	end

	// linear mode divides in S_SIZE; squared modes divide rounded in S_DIV_GO
	always_comb begin
		div_req.start = (state_q == S_DIV_GO) ||
			(state_q == S_SIZE && cfg.path_mode == PATH_LINEAR);
		if (state_q == S_SIZE) begin
			div_req.dividend = PROD_W'(t);
			div_req.divisor  = SQSUM_W'(n);
		end else begin
			div_req.dividend = prod_q + PROD_W'(sqsum_q >> 1);
			div_req.divisor  = sqsum_q;
		end
	end

	aesg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// step 0 takes up the rounding remainder, clamped at zero
	always_comb begin
		if (loop_q) begin
			if ({1'b0, first_q} + (PROD_W + 1)'(t) >= {1'b0, sum_q})
				cnt_full = first_q + PROD_W'(t) - sum_q;
			else
				cnt_full = '0;
		end else begin
			cnt_full = size_q;
		end
		cnt        = cnt_full[TRAVEL_W-1:0];
		step_next  = idx_q + STEP_W'(1);
		turn       = cfg.bounce_enable && !ret_q && (step_next == n);
		motion_new = (turn ? '0 : motion_q) + MOTION_W'(cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			ret_q    <= 1'b0;
			motion_q <= '0;
			sqsum_q  <= SQSUM_RST;
			k_q      <= '0;
			idx_q    <= '0;
			loop_q   <= 1'b0;
			prod_q   <= '0;
			acc_q    <= '0;
			sum_q    <= '0;
			first_q  <= '0;
			size_q   <= '0;
			res_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (restart) begin
							step_q   <= '0;
							ret_q    <= 1'b0;
							motion_q <= '0;
							k_q      <= STEP_W'(1);
							acc_q    <= '0;
							res_q    <= '0;
							if (n == '0) begin
								sqsum_q <= '0;
								state_q <= S_RESULT;
							end else begin
								state_q <= S_SQ_MUL;
							end
						end else if (step_q >= n) begin
							res_q.step_pixels   <= '0;
							res_q.motion_so_far <= motion_q;
							res_q.step_index    <= '0;
							res_q.return_phase  <= ret_q;
							res_q.active        <= 1'b0;
							state_q             <= S_RESULT;
						end else begin
							idx_q   <= step_q;
							k_q     <= step_q;
							loop_q  <= (step_q == '0);
							sum_q   <= '0;
							state_q <= S_SIZE;
						end
					end
				end
				S_SQ_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_SQ_ADD;
				end
				S_SQ_ADD: begin
					if (k_q == n) begin
						sqsum_q <= acc_new;
						state_q <= S_RESULT;
					end else begin
						acc_q   <= acc_new;
						k_q     <= k_q + STEP_W'(1);
						state_q <= S_SQ_MUL;
					end
				end
				S_SIZE: begin
					if (cfg.path_mode == PATH_FIXED) begin
						size_q  <= FIXED_STEP;
						state_q <= S_GOT;
					end else if (cfg.path_mode == PATH_LINEAR) begin
						state_q <= S_DIV_WAIT;
					end else if (is_sq && sqsum_q == '0) begin
						size_q  <= '0;
						state_q <= S_GOT;
					end else begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					prod_q  <= mul_p;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					prod_q  <= mul_p;
					state_q <= S_DIV_GO;
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						size_q  <= div_quo;
						state_q <= S_GOT;
					end
				end
				S_GOT: begin
					if (loop_q) begin
						sum_q <= sum_q + size_q;
						if (k_q == '0)
							first_q <= size_q;
						if (k_q == n - STEP_W'(1)) begin
							state_q <= S_FINISH;
						end else begin
							k_q     <= k_q + STEP_W'(1);
							state_q <= S_SIZE;
						end
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					step_q              <= turn ? '0 : step_next;
					ret_q               <= ret_q | turn;
					motion_q            <= motion_new;
					res_q.step_pixels   <= cnt;
					res_q.motion_so_far <= motion_new;
					res_q.step_index    <= idx_q;
					res_q.return_phase  <= ret_q;
					res_q.active        <= 1'b1;
					state_q             <= S_RESULT;
				end
				S_RESULT: begin
					if (res_take)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ready     = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESULT);
	assign res       = res_q;

endmodule

[rtl/core/animation_easing_step_generator_unit.sv]
// Eased animation step generator: top level with configuration registers and
// the result output register. Depends on aesg_pkg, aesg_seq and aesg_div.
//
// Usage: each frame tick is one transaction on tick_valid/tick_stall with the
// restart bit. restart=1 clears the step counter, return flag and motion and
// rebuilds the sum of squares. restart=0 takes one step: fixed mode uses a
// constant step size, linear mode divides through the bit-serial divider, and
// squared modes make two multiplier passes before the same divider.
// Step 0 of a pass sizes every step of the pass in turn, in linear and squared
// modes through the same divider. One item is in work at a time; tick_stall is
// high while the sequencer is busy.
// Each item yields one transaction on result_valid/result_stall. A finished
// result sits in the output register; the next tick is taken while it waits,
// and the sequencer holds its own result until the output register frees up.
// Configuration writes (cfg_valid/cfg_ready, always ready) should be made
// while the block is idle. Reset loads the register defaults (16 steps) and
// the matching sum of squares; no clearing pass is needed.
module animation_easing_step_generator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_valid,
	output logic                          tick_stall,
	input  logic                          restart,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [aesg_pkg::TRAVEL_W-1:0] step_pixels,
	output logic [aesg_pkg::MOTION_W-1:0] motion_so_far,
	output logic [aesg_pkg::STEP_W-1:0]   step_index,
	output logic                          return_phase,
	output logic                          active,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [aesg_pkg::TRAVEL_W-1:0] cfg_data
);
	import aesg_pkg::*;

	cfg_t    cfg_q;
	logic    out_valid_q;
	result_t out_q;
	logic    seq_ready;
	logic    seq_valid;
	logic    take;
	result_t seq_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.path_mode     <= PATH_LINEAR;
			cfg_q.step_count    <= STEP_W'(STEP_COUNT_RST);
			cfg_q.travel_total  <= '0;
			cfg_q.bounce_enable <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATH_MODE:    cfg_q.path_mode     <= path_mode_t'(cfg_data[1:0]);
				REG_STEP_COUNT:   cfg_q.step_count    <= cfg_data[STEP_W-1:0];
				REG_TRAVEL_TOTAL: cfg_q.travel_total  <= cfg_data;
				REG_BOUNCE:       cfg_q.bounce_enable <= cfg_data[0];
			endcase
		end
	end

	assign tick_stall = !seq_ready;
	assign take       = !out_valid_q || !result_stall;

	aesg_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (tick_valid && !tick_stall),
		.restart   (restart),
		.ready     (seq_ready),
		.res_valid (seq_valid),
		.res_take  (take),
		.res       (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= seq_valid;
	end

	always_ff @(posedge clk) begin
		if (take && seq_valid)
			out_q <= seq_res;
	end

	assign result_valid  = out_valid_q;
	assign step_pixels   = out_q.step_pixels;
	assign motion_so_far = out_q.motion_so_far;
	assign step_index    = out_q.step_index;
	assign return_phase  = out_q.return_phase;
	assign active        = out_q.active;

endmodule
